>>> rtl/swss_pkg.sv
package swss_pkg;

  // window geometry
  localparam int WINDOW_DEPTH = 10;
  localparam int PTR_W        = $clog2(WINDOW_DEPTH);
  localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);

  // sample and accumulator widths
  localparam int TEMP_W   = 16;
  localparam int PRESS_W  = 17;
  localparam int SUM_W    = TEMP_W + CNT_W;
  localparam int ALU_W    = SUM_W + 1;
  localparam int IT_W     = $clog2(SUM_W + 1);
  localparam int COUNT_OW = 4;

  // stream payload widths
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 56;

  // pressure trend codes
  typedef enum logic [1:0] {
    TREND_NONE    = 2'd0,
    TREND_RISING  = 2'd1,
    TREND_FALLING = 2'd2,
    TREND_STEADY  = 2'd3
  } trend_e;

endpackage

>>> rtl/swss_ram.sv
module swss_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // single write port, registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/sliding_window_sensor_stats_core.sv
// Sliding window temperature statistics with a pressure trend.
// Input stream (s_axis_*): one weather sample per request, temperature and
// pressure in hundredths of a unit. Output stream (m_axis_*): one result per
// sample with max, min and mean temperature over the last WINDOW_DEPTH
// samples, the pressure trend against the previous sample and the count of
// samples held in the window.
// One sample at a time: s_axis_tready is high only while the sequencer is
// idle. After a request is taken the sequencer walks the held entries through
// the window RAM (one read per entry, then the registered read data, then a
// check that the walk is done), forms the absolute sum, runs a restoring
// divide one quotient bit a cycle and fixes the sign, all on one shared
// add/subtract unit. The result then goes to the output register and the
// sequencer returns to idle, ready to take the next sample.
// The output register holds a result until m_axis_tready takes it; the next
// sample may be accepted meanwhile, and its result waits in the sequencer
// until the output register is free.
// Reset clears the fill count, the write pointer, the previous pressure and
// the output valid; window RAM contents need no reset.
module sliding_window_sensor_stats_core
  import swss_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [15:0] temperature, [32:16] pressure, [39:33] zero
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [15:0] temp_max, [31:16] temp_min, [47:32] temp_mean,
  // [49:48] pressure_trend, [53:50] sample_count, [55:54] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_READ = 6'b000010,
    ST_ABS  = 6'b000100,
    ST_DIV  = 6'b001000,
    ST_NEG  = 6'b010000,
    ST_OUT  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [CNT_W-1:0]   fill_q, fill_d;
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PRESS_W-1:0] last_press_q, last_press_d;
  trend_e             trend_q, trend_d;
  logic [CNT_W-1:0]   rd_idx_q, rd_idx_d;
  logic               rd_vld_q, rd_vld_d;
  logic [SUM_W-1:0]   sum_q, sum_d;
  logic [TEMP_W-1:0]  max_q, max_d;
  logic [TEMP_W-1:0]  min_q, min_d;
  logic               neg_q, neg_d;
  logic [SUM_W-1:0]   quot_q, quot_d;
  logic [CNT_W:0]     rem_q, rem_d;
  logic [IT_W-1:0]    it_q, it_d;
  logic [TEMP_W-1:0]  mean_q, mean_d;

  logic                  out_vld_q, out_vld_d;
  logic [OUT_DATA_W-1:0] out_data_q, out_data_d;

  logic                  in_fire;
  logic [TEMP_W-1:0]     in_temp;
  logic [PRESS_W-1:0]    in_press;
  logic [TEMP_W-1:0]     rd_data;

  // shared add/subtract unit
  logic [ALU_W-1:0] alu_a, alu_b, alu_res;
  logic             alu_sub;

  logic [CNT_W:0]          rem_sh;
  logic                    div_ge;
  logic [CNT_W+COUNT_OW-1:0] count_ext;

  assign in_temp  = s_axis_tdata[TEMP_W-1:0];
  assign in_press = s_axis_tdata[TEMP_W+PRESS_W-1:TEMP_W];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // window storage
  swss_ram #(
    .WIDTH(TEMP_W),
    .DEPTH(WINDOW_DEPTH)
  ) u_window (
    .clk_i  (clk_i),
    .we_i   (in_fire),
    .waddr_i(wr_ptr_q),
    .wdata_i(in_temp),
    .raddr_i(rd_idx_q[PTR_W-1:0]),
    .rdata_o(rd_data)
  );

  // divide step operands
  assign rem_sh = {rem_q[CNT_W-1:0], quot_q[SUM_W-1]};
  assign div_ge = ~alu_res[ALU_W-1];

  // operand selection for the shared unit
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state_q)
      ST_READ: begin
        alu_a = {sum_q[SUM_W-1], sum_q};
        alu_b = {{(ALU_W-TEMP_W){rd_data[TEMP_W-1]}}, rd_data};
      end
      ST_ABS: begin
        alu_b   = {sum_q[SUM_W-1], sum_q};
        alu_sub = 1'b1;
      end
      ST_DIV: begin
        alu_a   = {{(ALU_W-CNT_W-1){1'b0}}, rem_sh};
        alu_b   = {{(ALU_W-CNT_W){1'b0}}, fill_q};
        alu_sub = 1'b1;
      end
      ST_NEG: begin
        alu_b   = {1'b0, quot_q};
        alu_sub = 1'b1;
      end
      default: begin
        alu_sub = 1'b0;
      end
    endcase
  end

  assign alu_res = alu_a + (alu_sub ? ~alu_b : alu_b) + {{(ALU_W-1){1'b0}}, alu_sub};

  assign count_ext = {{COUNT_OW{1'b0}}, fill_q};

  // sequencer
  always_comb begin
    state_d      = state_q;
    fill_d       = fill_q;
    wr_ptr_d     = wr_ptr_q;
    last_press_d = last_press_q;
    trend_d      = trend_q;
    rd_idx_d     = rd_idx_q;
    rd_vld_d     = 1'b0;
    sum_d        = sum_q;
    max_d        = max_q;
    min_d        = min_q;
    neg_d        = neg_q;
    quot_d       = quot_q;
    rem_d        = rem_q;
    it_d         = it_q;
    mean_d       = mean_q;
    out_vld_d    = out_vld_q;
    out_data_d   = out_data_q;

    // output register drains independently of the sequencer
    if (out_vld_q && m_axis_tready) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          // insert sample, saturate the fill count
          if (fill_q != CNT_W'(WINDOW_DEPTH)) begin
            fill_d = fill_q + CNT_W'(1);
          end
          if (wr_ptr_q == PTR_W'(WINDOW_DEPTH - 1)) begin
            wr_ptr_d = '0;
          end else begin
            wr_ptr_d = wr_ptr_q + PTR_W'(1);
          end
          // trend against the previous pressure
          if (fill_q == '0) begin
            trend_d = TREND_NONE;
          end else if (last_press_q < in_press) begin
            trend_d = TREND_RISING;
          end else if (last_press_q > in_press) begin
            trend_d = TREND_FALLING;
          end else begin
            trend_d = TREND_STEADY;
          end
          last_press_d = in_press;
          rd_idx_d     = '0;
          sum_d        = '0;
          max_d        = {1'b1, {(TEMP_W-1){1'b0}}};
          min_d        = {1'b0, {(TEMP_W-1){1'b1}}};
          state_d      = ST_READ;
        end
      end
      ST_READ: begin
        // issue reads of every held entry, order does not matter
        if (rd_idx_q < fill_q) begin
          rd_idx_d = rd_idx_q + CNT_W'(1);
          rd_vld_d = 1'b1;
        end
        if (rd_vld_q) begin
          sum_d = alu_res[SUM_W-1:0];
          if ($signed(rd_data) > $signed(max_q)) begin
            max_d = rd_data;
          end
          if ($signed(rd_data) < $signed(min_q)) begin
            min_d = rd_data;
          end
        end else if (rd_idx_q == fill_q) begin
          state_d = ST_ABS;
        end
      end
      ST_ABS: begin
        neg_d   = sum_q[SUM_W-1];
        quot_d  = sum_q[SUM_W-1] ? alu_res[SUM_W-1:0] : sum_q;
        rem_d   = '0;
        it_d    = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        // restoring divide, one quotient bit per cycle
        rem_d  = div_ge ? alu_res[CNT_W:0] : rem_sh;
        quot_d = {quot_q[SUM_W-2:0], div_ge};
        it_d   = it_q + IT_W'(1);
        if (it_q == IT_W'(SUM_W - 1)) begin
          state_d = ST_NEG;
        end
      end
      ST_NEG: begin
        mean_d  = neg_q ? alu_res[TEMP_W-1:0] : quot_q[TEMP_W-1:0];
        state_d = ST_OUT;
      end
      ST_OUT: begin
        // wait for a free output register
        if (!out_vld_q || m_axis_tready) begin
          out_vld_d  = 1'b1;
          out_data_d = {2'b00, count_ext[COUNT_OW-1:0], trend_q, mean_q, min_q, max_q};
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      fill_q       <= '0;
      wr_ptr_q     <= '0;
      last_press_q <= '0;
      rd_vld_q     <= 1'b0;
      out_vld_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      fill_q       <= fill_d;
      wr_ptr_q     <= wr_ptr_d;
      last_press_q <= last_press_d;
      rd_vld_q     <= rd_vld_d;
      out_vld_q    <= out_vld_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    trend_q    <= trend_d;
    rd_idx_q   <= rd_idx_d;
    sum_q      <= sum_d;
    max_q      <= max_d;
    min_q      <= min_d;
    neg_q      <= neg_d;
    quot_q     <= quot_d;
    rem_q      <= rem_d;
    it_q       <= it_d;
    mean_q     <= mean_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

endmodule

>>> test/swss_stats_checker.sv
module swss_stats_checker
  import swss_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  // [15:0] temperature, [32:16] pressure, [39:33] zero
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [15:0] temp_max, [31:16] temp_min, [47:32] temp_mean,
  // [49:48] pressure_trend, [53:50] sample_count, [55:54] zero
  input  logic [OUT_DATA_W-1:0] m_axis_tdata,
  output int                    fail_count_o,
  output int                    pending_o,
  output int                    checked_o
);

  typedef struct {
    logic signed [TEMP_W-1:0] t_max;
    logic signed [TEMP_W-1:0] t_min;
    logic signed [TEMP_W-1:0] t_mean;
    trend_e                   trend;
    logic [COUNT_OW-1:0]      count;
  } stats_t;

  // predicted window contents and history
  logic signed [TEMP_W-1:0] window_q [WINDOW_DEPTH];
  int                       held;
  logic [PRESS_W-1:0]       prev_press;
  stats_t                   stats_due [$];

  // append one sample to the window and work out its statistics
  function automatic stats_t predict_window_stats(logic signed [TEMP_W-1:0] temp,
                                                  logic [PRESS_W-1:0] press);
    stats_t r;
    int     sum;
    int     hi;
    int     lo;
    int     v;
    int     mean;
    if (held < WINDOW_DEPTH) begin
      window_q[held] = temp;
      held++;
    end else begin
      for (int i = 0; i < WINDOW_DEPTH - 1; i++) window_q[i] = window_q[i+1];
      window_q[WINDOW_DEPTH-1] = temp;
    end
    hi  = window_q[0];
    lo  = window_q[0];
    sum = 0;
    for (int i = 0; i < held; i++) begin
      v = window_q[i];
      if (v > hi) hi = v;
      if (v < lo) lo = v;
      sum += v;
    end
    // int division truncates toward zero
    mean     = sum / held;
    r.t_max  = hi[TEMP_W-1:0];
    r.t_min  = lo[TEMP_W-1:0];
    r.t_mean = mean[TEMP_W-1:0];
    if (held == 1)              r.trend = TREND_NONE;
    else if (prev_press < press) r.trend = TREND_RISING;
    else if (prev_press > press) r.trend = TREND_FALLING;
    else                         r.trend = TREND_STEADY;
    r.count    = held[COUNT_OW-1:0];
    prev_press = press;
    return r;
  endfunction

  // watch both channels, compare results against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    stats_t want;
    if (!rst_ni) begin
      held         = 0;
      prev_press   = '0;
      stats_due.delete();
      fail_count_o = 0;
      checked_o    = 0;
      pending_o    = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (stats_due.size() == 0) begin
          $error("result with no request outstanding: data %h", m_axis_tdata);
          fail_count_o++;
        end else begin
          want = stats_due.pop_front();
          checked_o++;
          if (m_axis_tdata[15:0] !== want.t_max) begin
            $error("temp_max: expected %0d, actual %0d", want.t_max,
                   $signed(m_axis_tdata[15:0]));
            fail_count_o++;
          end
          if (m_axis_tdata[31:16] !== want.t_min) begin
            $error("temp_min: expected %0d, actual %0d", want.t_min,
                   $signed(m_axis_tdata[31:16]));
            fail_count_o++;
          end
          if (m_axis_tdata[47:32] !== want.t_mean) begin
            $error("temp_mean: expected %0d, actual %0d", want.t_mean,
                   $signed(m_axis_tdata[47:32]));
            fail_count_o++;
          end
          if (m_axis_tdata[49:48] !== want.trend) begin
            $error("pressure_trend: expected %0d, actual %0d", want.trend,
                   m_axis_tdata[49:48]);
            fail_count_o++;
          end
          if (m_axis_tdata[53:50] !== want.count) begin
            $error("sample_count: expected %0d, actual %0d", want.count,
                   m_axis_tdata[53:50]);
            fail_count_o++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        stats_due.push_back(predict_window_stats(s_axis_tdata[TEMP_W-1:0],
                                                 s_axis_tdata[TEMP_W+PRESS_W-1:TEMP_W]));
      end
      pending_o = stats_due.size();
    end
  end

endmodule

>>> test/tb.sv
module tb;
  import swss_pkg::*;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int RANDOM_ITEMS = 1630;
  localparam int DRAIN_CYCLES = 60;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  int fail_count;
  int pending;
  int checked;
  int sent;
  int cycles;
  int tx_gap_max;
  int rx_gap_max;

  sliding_window_sensor_stats_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  swss_stats_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .checked_o     (checked)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // one sample request with a random lead-in gap
  task automatic send_sample(input logic signed [TEMP_W-1:0] temp,
                             input logic [PRESS_W-1:0] press);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_DATA_W-TEMP_W-PRESS_W){1'b0}}, press, temp};
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    @(negedge clk_i);
    sent++;
  endtask

  // result side: random stall before each result, bursts with no stall
  initial begin
    int stall;
    int taken;
    m_axis_tready = 1'b0;
    rx_gap_max    = 14;
    taken         = 0;
    @(posedge rst_ni);
    @(negedge clk_i);
    stall = $urandom_range(0, rx_gap_max);
    forever begin
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
      @(negedge clk_i);
      taken++;
      if (taken % 50 == 0) rx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 14;
      stall = $urandom_range(0, rx_gap_max);
    end
  end

  // stimulus and verdict
  initial begin
    logic signed [TEMP_W-1:0] temp;
    logic [PRESS_W-1:0]       press;
    int                       pick;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    rst_ni        = 1'b0;
    sent          = 0;
    tx_gap_max    = 14;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: first sample, field extremes, every trend, window rollover
    send_sample(16'sd100, 17'd1000);
    send_sample(16'sd32767, 17'd1000);
    send_sample(-16'sd32768, 17'd2000);
    send_sample(-16'sd1, 17'd0);
    send_sample(16'sd0, 17'd131071);
    send_sample(-16'sd2, 17'd131071);
    send_sample(-16'sd3, 17'd131070);
    send_sample(16'sd32767, 17'd65536);
    send_sample(16'sd32767, 17'd65537);
    send_sample(-16'sd32768, 17'd65537);
    // window full, oldest drops from here on
    send_sample(-16'sd32768, 17'd0);
    send_sample(-16'sd32768, 17'd1);
    send_sample(-16'sd32768, 17'd1);
    send_sample(-16'sd32768, 17'd131071);
    send_sample(-16'sd32768, 17'd0);
    send_sample(-16'sd32768, 17'd43690);
    send_sample(-16'sd32768, 17'd87381);
    send_sample(-16'sd32767, 17'd87381);
    send_sample(-16'sd1, 17'd2);
    send_sample(16'sd1, 17'd1);
    send_sample(16'sd32767, 17'd1);
    send_sample(16'sd2178, 17'd76012);

    temp  = 16'sd2178;
    press = 17'd76012;
    // random: realistic drift, extremes and full-range noise
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 60 == 0) tx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 14;
      pick = $urandom_range(0, 9);
      if (pick < 3)      temp = $signed(16'($urandom()));
      else if (pick < 5) temp = 16'sd32767 - $signed(16'($urandom_range(0, 40)));
      else if (pick < 7) temp = -16'sd32768 + $signed(16'($urandom_range(0, 40)));
      else               temp = temp + $signed(16'($urandom_range(0, 200))) - 16'sd100;
      pick = $urandom_range(0, 9);
      if (pick < 3)      press = press;
      else if (pick < 6) press = press + 17'($urandom_range(0, 20)) - 17'd10;
      else               press = 17'($urandom());
      send_sample(temp, press);
      // hold off until everything requested so far has come back
      if (n % 400 == 399) begin
        s_axis_tvalid <= 1'b0;
        wait (pending == 0);
        @(negedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b0;

    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("sent %0d samples, checked %0d results, window depth %0d",
             sent, checked, WINDOW_DEPTH);
    $display("covered field extremes, all trends, window rollover, gaps and stalls");
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/swss_pkg.sv
rtl/swss_ram.sv
rtl/sliding_window_sensor_stats_core.sv
test/swss_stats_checker.sv
test/tb.sv
